// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the pair-sum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SWPS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SWPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== design/swps_pkg.sv =====
// Shared types and constants of the sliding-window pair-sum checker.
`default_nettype none

package swps_pkg;

	localparam int VALUE_W = 63;
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] LEN_RESET = 6'd25;
	localparam int LEN_MIN = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SETTLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic search;
		logic rotate;
		logic shift_in;
	} win_cmd_t;

endpackage

`default_nettype wire

// ===== design/swps_window.sv =====
// Window taps with the shared subtractor and per-lane equality compare.
`default_nettype none

module swps_window #(
	parameter int MAX_WINDOW = 32,
	localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  swps_pkg::win_cmd_t            cmd,
	input  wire [CNT_W-1:0]               len,
	input  wire [swps_pkg::VALUE_W-1:0]   target,
	output logic                          hit_any
);
	import swps_pkg::*;

	logic [VALUE_W-1:0] win_q [MAX_WINDOW];
	logic [VALUE_W:0] diff;
	logic borrow;
	logic [CNT_W-1:0] last_idx;
	logic [MAX_WINDOW-1:0] lane_hit;
	logic [MAX_WINDOW-1:0] hits_q;

	// The entry at the head is the candidate; the others are searched for its complement.
	assign diff = {1'b0, target} - {1'b0, win_q[0]};
	assign borrow = diff[VALUE_W];
	assign last_idx = len - CNT_W'(1);

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_lane
		localparam logic [CNT_W-1:0] LANE = CNT_W'(g);

		if (g == 0) begin : g_head
			assign lane_hit[g] = 1'b0;
			always_ff @(posedge clk) begin
				if (cmd.shift_in) begin
					win_q[g] <= target;
				end else if (cmd.rotate) begin
					win_q[g] <= win_q[g+1];
				end
			end
		end else begin : g_body
			assign lane_hit[g] = !borrow && (LANE < len) &&
				(win_q[g] == diff[VALUE_W-1:0]);
			if (g < MAX_WINDOW - 1) begin : g_mid
				// Only the first len entries rotate, so older entries stay put.
				always_ff @(posedge clk) begin
					if (cmd.shift_in) begin
						win_q[g] <= win_q[g-1];
					end else if (cmd.rotate) begin
						if (LANE < last_idx) begin
							win_q[g] <= win_q[g+1];
						end else if (LANE == last_idx) begin
							win_q[g] <= win_q[0];
						end
					end
				end
			end else begin : g_tail
				always_ff @(posedge clk) begin
					if (cmd.shift_in) begin
						win_q[g] <= win_q[g-1];
					end else if (cmd.rotate && (LANE == last_idx)) begin
						win_q[g] <= win_q[0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else begin
			hits_q <= cmd.search ? lane_hit : '0;
		end
	end

	assign hit_any = |hits_q;

endmodule

`default_nettype wire

// ===== design/swps_ctrl.sv =====
// Sequencer, configuration register and result register of the pair-sum checker.
`default_nettype none

module swps_ctrl #(
	parameter int MAX_WINDOW = 32,
	localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [swps_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [swps_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          checked,
	output logic                          has_pair,
	output logic                          first_invalid,
	output logic [swps_pkg::VALUE_W-1:0]  value_out,
	input  wire                           hit_any,
	output swps_pkg::win_cmd_t            cmd,
	output logic [CNT_W-1:0]              len,
	output logic [swps_pkg::VALUE_W-1:0]  target
);
	import swps_pkg::*;

	localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t state_q, state_d;
	logic [CFG_W-1:0] window_len_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] step_q;
	logic failure_q;
	logic found_q;
	logic checked_q;
	logic [VALUE_W-1:0] value_q;
	logic out_valid_q;
	logic checked_out_q;
	logic pair_out_q;
	logic first_out_q;
	logic [VALUE_W-1:0] value_out_q;
	logic [WIDE_W-1:0] len_wide;
	logic accept;
	logic out_free;
	logic emit;

	// Out-of-range lengths are clamped to the supported window.
	assign len_wide = WIDE_W'(window_len_q);
	always_comb begin
		if (len_wide < WIDE_W'(LEN_MIN)) begin
			len = CNT_W'(LEN_MIN);
		end else if (len_wide > WIDE_W'(MAX_WINDOW)) begin
			len = CNT_W'(MAX_WINDOW);
		end else begin
			len = len_wide[CNT_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (fill_q >= len) ? ST_SEARCH : ST_EMIT;
				end
			end
			ST_SEARCH: begin
				if (step_q == len - CNT_W'(1)) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd = '0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				cmd.rotate = 1'b1;
			end
			ST_SETTLE: begin
			end
			ST_EMIT: begin
				emit = out_free;
				cmd.shift_in = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_len_q <= LEN_RESET;
			fill_q <= '0;
			step_q <= '0;
			failure_q <= 1'b0;
			found_q <= 1'b0;
			checked_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_len_q <= cfg_wdata;
			end
			if (accept) begin
				checked_q <= (fill_q >= len);
				found_q <= 1'b0;
				step_q <= '0;
			end
			// Compare results are registered in the window before they reach found, hence the settle state.
			if ((state_q == ST_SEARCH) || (state_q == ST_SETTLE)) begin
				found_q <= found_q | hit_any;
			end
			if (state_q == ST_SEARCH) begin
				step_q <= step_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (checked_q && !found_q) begin
					failure_q <= 1'b1;
				end
				if (fill_q != CNT_W'(MAX_WINDOW)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end
		if (emit) begin
			checked_out_q <= checked_q;
			pair_out_q <= checked_q && found_q;
			first_out_q <= checked_q && !found_q && !failure_q;
			value_out_q <= value_q;
		end
	end

	assign target = value_q;
	assign out_valid = out_valid_q;
	assign checked = checked_out_q;
	assign has_pair = pair_out_q;
	assign first_invalid = first_out_q;
	assign value_out = value_out_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_pair_sum_check_top.sv =====
// Top level of the sliding-window pair-sum checker.
// Each item is checked against the window_len values before it (clamped to 2..MAX_WINDOW):
// one shared 63-bit subtractor forms the complement of one window entry per cycle and the other
// window taps in use compare against it at once. A checked item passes through the idle (accept),
// search, settle and emit states, an unchecked one through idle and emit only, and the input
// stays stalled meanwhile. The result register lets the next item be taken while a result still
// waits downstream. There is no clearing pass after reset.
`default_nettype none

module sliding_window_pair_sum_check_top #(
	parameter int MAX_WINDOW = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [swps_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [swps_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          checked,
	output logic                          has_pair,
	output logic                          first_invalid,
	output logic [swps_pkg::VALUE_W-1:0]  value_out
);
	import swps_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	win_cmd_t cmd;
	logic [CNT_W-1:0] len;
	logic [VALUE_W-1:0] target;
	logic hit_any;

	swps_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.checked      (checked),
		.has_pair     (has_pair),
		.first_invalid(first_invalid),
		.value_out    (value_out),
		.hit_any      (hit_any),
		.cmd          (cmd),
		.len          (len),
		.target       (target)
	);

	swps_window #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.len    (len),
		.target (target),
		.hit_any(hit_any)
	);

endmodule

`default_nettype wire

// ===== design/swps_checker.sv =====
// Port-level checker of the pair-sum block and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module swps_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire                           checked,
	input wire                           has_pair,
	input wire                           first_invalid,
	input wire [swps_pkg::VALUE_W-1:0]   value_out
);
	logic seen_q;

	// Remembers that a first failure has already been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && !out_stall && first_invalid) begin
			seen_q <= 1'b1;
		end
	end

	`SWPS_ASSERT_IMPL(a_pair_needs_check, out_valid && has_pair, checked)
	`SWPS_ASSERT_IMPL(a_first_is_failure, out_valid && first_invalid, checked && !has_pair)
	`SWPS_ASSERT_IMPL(a_first_only_once, out_valid && first_invalid, !seen_q)
	`SWPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`SWPS_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(value_out))

endmodule

bind sliding_window_pair_sum_check_top swps_checker u_swps_checker (.*);

`default_nettype wire
